/* rtl/pate_pkg.sv */
// shared types and constants for the packed array table engine
// operation codes, status codes and the result word layout; no dependencies

package pate_pkg;

    // field widths of the stream words
    localparam int FUNC_W  = 3;
    localparam int INDEX_W = 8;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 8;
    localparam int FILL_W  = 9;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_SEARCH = 3'd0;
    localparam logic [FUNC_W-1:0] OP_MODIFY = 3'd1;
    localparam logic [FUNC_W-1:0] OP_APPEND = 3'd2;
    localparam logic [FUNC_W-1:0] OP_ZERO   = 3'd3;
    localparam logic [FUNC_W-1:0] OP_REMOVE = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

    // one result word as handed from the sequencer to the output stage
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] old_value;
        logic [VALUE_W-1:0] new_value;
        logic [FILL_W-1:0]  fill_count;
    } res_t;

endpackage

/* rtl/packed_array_table_engine.sv */
// top level of the packed array table engine: stream ports and output register
// uses pate_pkg and pate_ctrl (which holds the table ram)

// Packed table of up to CAPACITY signed 32-bit entries with a fill count. Each
// input word carries an operation (search, modify, append, zero entry, remove
// entry), an index and a value, and gives exactly one result word with a status,
// the matching position of a search, the old and new values of a modify, and the
// fill count after the operation. One word is worked on at a time. Search and
// remove walk the table ram, which has one read port and returns one entry per
// cycle, so they take longer than modify, append and zero. The result sits in
// an output register, so the next word is taken while the previous result
// still waits.

module packed_array_table_engine #(
    parameter int CAPACITY = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // index[7:0], value[39:8]
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // position[7:0], old_value[39:8],
                                        // new_value[71:40], fill_count[80:72], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    logic           res_valid;
    logic           res_ready;
    pate_pkg::res_t res;

    logic           out_valid_reg, out_valid_next;
    pate_pkg::res_t out_reg, out_next;

    // sequencer with the table
    pate_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_index  (s_axis_tdata[7:0]),
        .in_value  (s_axis_tdata[39:8]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register takes a result when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // result word packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {7'd0, out_reg.fill_count, out_reg.new_value,
                            out_reg.old_value, out_reg.position};

endmodule

/* rtl/pate_ram.sv */
// generic single-clock ram: one write port, one read port, registered read
// no dependencies

module pate_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/pate_ctrl.sv */
// sequencer of the packed array table engine: range checks, table walk and shift
// uses pate_pkg for codes and the result word, and holds the table in pate_ram

module pate_ctrl #(
    parameter int CAPACITY = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pate_pkg::FUNC_W-1:0]    in_func,
    input  logic [pate_pkg::INDEX_W-1:0]   in_index,
    input  logic [pate_pkg::VALUE_W-1:0]   in_value,
    output logic                           res_valid,
    input  logic                           res_ready,
    output pate_pkg::res_t                 res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = CW + pate_pkg::INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MOD_WR,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t                         state_reg, state_next;
    logic [pate_pkg::FUNC_W-1:0]    func_reg, func_next;
    logic [pate_pkg::INDEX_W-1:0]   idx_reg, idx_next;
    logic [pate_pkg::VALUE_W-1:0]   value_reg, value_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  ptr_reg, ptr_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]                  cmp_ptr_reg, cmp_ptr_next;
    pate_pkg::res_t                 res_reg, res_next;

    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [pate_pkg::VALUE_W-1:0]   wr_data;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [pate_pkg::VALUE_W-1:0]   rd_data;

    logic                           idx_bad;
    logic [AW-1:0]                  idx_addr;
    logic [CW-1:0]                  last_pos;
    logic                           hit;

    // table storage
    pate_ram #(
        .WIDTH (pate_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // range check, entry address and the shared compare
    assign idx_bad  = EW'(idx_reg) >= EW'(count_reg);
    assign idx_addr = AW'(idx_reg);
    assign last_pos = count_reg - CW'(1);
    assign hit      = cmp_valid_reg && (rd_data == value_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // next state, table port control and result
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        idx_next       = idx_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_ptr_next   = cmp_ptr_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_addr;
        wr_data        = value_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_addr;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = in_func;
                    idx_next   = in_index;
                    value_next = in_value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next.status    = pate_pkg::ST_OK;
                res_next.position  = '0;
                res_next.old_value = '0;
                res_next.new_value = '0;
                ptr_next           = '0;
                cmp_valid_next     = 1'b0;
                state_next         = S_DONE;
                case (func_reg)
                    pate_pkg::OP_SEARCH:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = pate_pkg::ST_MISSING;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    pate_pkg::OP_MODIFY:
                    begin
                        if (idx_bad)
                        begin
                            res_next.status = pate_pkg::ST_RANGE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            state_next = S_MOD_WR;
                        end
                    end
                    pate_pkg::OP_APPEND:
                    begin
                        if (EW'(count_reg) >= EW'(CAPACITY))
                        begin
                            res_next.status = pate_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    pate_pkg::OP_ZERO:
                    begin
                        if (idx_bad)
                        begin
                            res_next.status = pate_pkg::ST_RANGE;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_data = '0;
                        end
                    end
                    pate_pkg::OP_REMOVE:
                    begin
                        if (idx_bad)
                        begin
                            res_next.status = pate_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ptr_next   = CW'(idx_reg) + CW'(1);
                            state_next = S_SHIFT;
                        end
                    end
                    default:
                    begin
                        // unused codes leave the table alone
                    end
                endcase
            end

            // old entry is back from the ram; overwrite it
            S_MOD_WR:
            begin
                wr_en              = 1'b1;
                res_next.old_value = rd_data;
                res_next.new_value = value_reg;
                state_next         = S_DONE;
            end

            // read one entry a cycle, compare the one read the cycle before
            S_SCAN:
            begin
                if (hit)
                begin
                    res_next.position = pate_pkg::POS_W'(cmp_ptr_reg);
                    state_next        = S_DONE;
                end
                else if (cmp_valid_reg && (cmp_ptr_reg == last_pos))
                begin
                    res_next.status = pate_pkg::ST_MISSING;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = AW'(ptr_reg);
                    cmp_valid_next = 1'b1;
                    cmp_ptr_next   = ptr_reg;
                    ptr_next       = ptr_reg + CW'(1);
                end
            end

            // read entry ptr, write it one place lower the next cycle
            S_SHIFT:
            begin
                if (cmp_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(cmp_ptr_reg - CW'(1));
                    wr_data = rd_data;
                end
                if (ptr_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = AW'(ptr_reg);
                    cmp_valid_next = 1'b1;
                    cmp_ptr_next   = ptr_reg;
                    ptr_next       = ptr_reg + CW'(1);
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                    if (!cmp_valid_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_next.fill_count = pate_pkg::FILL_W'(count_next);
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            func_reg      <= '0;
            idx_reg       <= '0;
            value_reg     <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_ptr_reg   <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            idx_reg       <= idx_next;
            value_reg     <= value_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_ptr_reg   <= cmp_ptr_next;
            res_reg       <= res_next;
        end
    end

    // fill count never passes the capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(count_reg) <= EW'(CAPACITY))
        else $error("fill count above capacity");

    // a taken word starts work at once
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted word did not start");

    // writes stay inside the packed part or land at its end
    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CW'(wr_addr) <= count_reg))
        else $error("write beyond the end of the table");

    // the walk never reads past the fill count
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && (state_reg == S_SCAN || state_reg == S_SHIFT))
            |-> (CW'(rd_addr) < count_reg))
        else $error("read beyond the fill count");

endmodule
